[design/bsmr_pkg.sv]
// ----------------------------------------------------------------------------
// bsmr_pkg
// Shared command, status and sequencer codes for the min-tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmr_pkg;

  localparam int ValueW = 32;
  localparam int OutCountW = 6;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

endpackage

`default_nettype wire

[design/bsmr_level_mem.sv]
// ----------------------------------------------------------------------------
// bsmr_level_mem
// Per-level record of the running minimum and its slot: one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmr_level_mem
  import bsmr_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int AW     = 5,
  parameter int DATA_W = 37
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/bounded_stack_with_min_rank.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_min_rank
// Fixed-depth stack of signed values reporting its minimum and the minimum's
// rank from the top after every command.
// ----------------------------------------------------------------------------
// One command is in flight at a time. Push, clear, a refused command and the
// unused code have their result word registered at the edge that takes them;
// a pop that leaves at least one entry first passes through S_READ, since the
// new top's minimum record comes from the level memory, whose read data is
// registered. The running minimum of the top level is held in a register, so
// a push only writes the memory. A new command is taken only at an edge where
// the output register is empty or its word is being accepted; while a result
// word waits on out_stall, in_stall stays high.
`default_nettype none

module bounded_stack_with_min_rank
  import bsmr_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_cmd,
  input  wire logic signed [31:0]   in_push_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic                      out_is_empty,
  output logic                      out_is_full,
  output logic [5:0]                out_depth,
  output logic signed [31:0]        out_min_value,
  output logic [5:0]                out_min_rank
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW = ValueW + AW;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic signed [ValueW-1:0]   top_min_r, top_min_nxt;
  logic [AW-1:0]              top_slot_r, top_slot_nxt;

  logic                       out_valid_r, out_valid_nxt;
  status_t                    out_status_r, out_status_nxt;
  logic                       out_is_empty_r, out_is_empty_nxt;
  logic                       out_is_full_r, out_is_full_nxt;
  logic [OutCountW-1:0]       out_depth_r, out_depth_nxt;
  logic signed [ValueW-1:0]   out_min_value_r, out_min_value_nxt;
  logic [OutCountW-1:0]       out_min_rank_r, out_min_rank_nxt;

  logic                       in_take;
  logic                       push_le;
  logic signed [ValueW-1:0]   push_min;
  logic [AW-1:0]              push_slot;

  logic                       wr_en, rd_en;
  logic [AW-1:0]              rd_addr;
  logic [DW-1:0]              rd_data;
  logic signed [ValueW-1:0]   rd_min;
  logic [AW-1:0]              rd_slot;

  logic                       load;
  status_t                    res_status;
  logic [CW-1:0]              res_fill;
  logic signed [ValueW-1:0]   res_min;
  logic [AW-1:0]              res_slot;
  logic [31:0]                res_depth32;
  logic [31:0]                res_rank32;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;

  // ties go to the newer entry, which lies above
  assign push_le   = (fill_r == '0) || (in_push_value <= top_min_r);
  assign push_min  = push_le ? in_push_value : top_min_r;
  assign push_slot = push_le ? fill_r[AW-1:0] : top_slot_r;

  assign rd_min  = rd_data[DW-1:AW];
  assign rd_slot = rd_data[AW-1:0];
  assign rd_addr = AW'(fill_r - CW'(2));

  bsmr_level_mem #(
    .DEPTH  (CAPACITY),
    .AW     (AW),
    .DATA_W (DW)
  ) u_level_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data ({push_min, push_slot}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    top_min_nxt  = top_min_r;
    top_slot_nxt = top_slot_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    load         = 1'b0;
    res_status   = ST_DONE;
    res_fill     = fill_r;
    res_min      = top_min_r;
    res_slot     = top_slot_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          load = 1'b1;
          case (in_cmd)
            CMD_PUSH: begin
              if (fill_r == CW'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                fill_nxt     = fill_r + CW'(1);
                top_min_nxt  = push_min;
                top_slot_nxt = push_slot;
                res_fill     = fill_nxt;
                res_min      = push_min;
                res_slot     = push_slot;
              end
            end
            CMD_POP: begin
              if (fill_r == '0) begin
                res_status = ST_EMPTY;
              end else if (fill_r > CW'(1)) begin
                // new top record comes back from memory next cycle
                load      = 1'b0;
                rd_en     = 1'b1;
                fill_nxt  = fill_r - CW'(1);
                state_nxt = S_READ;
              end else begin
                fill_nxt = '0;
                res_fill = '0;
              end
            end
            CMD_CLEAR: begin
              fill_nxt = '0;
              res_fill = '0;
            end
            default: begin
              res_status = ST_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        load         = 1'b1;
        top_min_nxt  = rd_min;
        top_slot_nxt = rd_slot;
        res_min      = rd_min;
        res_slot     = rd_slot;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_depth32 = 32'(res_fill);
  assign res_rank32  = 32'(res_fill - CW'(res_slot));

  always_comb begin
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_is_empty_nxt  = out_is_empty_r;
    out_is_full_nxt   = out_is_full_r;
    out_depth_nxt     = out_depth_r;
    out_min_value_nxt = out_min_value_r;
    out_min_rank_nxt  = out_min_rank_r;
    if (load) begin
      out_valid_nxt     = 1'b1;
      out_status_nxt    = res_status;
      out_is_empty_nxt  = (res_fill == '0);
      out_is_full_nxt   = (res_fill == CW'(CAPACITY));
      out_depth_nxt     = res_depth32[OutCountW-1:0];
      out_min_value_nxt = (res_fill == '0) ? '0 : res_min;
      out_min_rank_nxt  = (res_fill == '0) ? '0 : res_rank32[OutCountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_min_r       <= top_min_nxt;
    top_slot_r      <= top_slot_nxt;
    out_status_r    <= out_status_nxt;
    out_is_empty_r  <= out_is_empty_nxt;
    out_is_full_r   <= out_is_full_nxt;
    out_depth_r     <= out_depth_nxt;
    out_min_value_r <= out_min_value_nxt;
    out_min_rank_r  <= out_min_rank_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_is_empty  = out_is_empty_r;
  assign out_is_full   = out_is_full_r;
  assign out_depth     = out_depth_r;
  assign out_min_value = out_min_value_r;
  assign out_min_rank  = out_min_rank_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> in_stall)
    else $error("input taken while a pop waits on memory");

  a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> out_valid)
    else $error("pop result word not registered after memory read");

  a_empty_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_min_rank == '0 && out_min_value == '0)
    else $error("empty stack reports a minimum");

endmodule

`default_nettype wire

[test/bsmr_checker.sv]
// ----------------------------------------------------------------------------
// bsmr_checker
// Watches the command and report channels of the min-tracking stack. It keeps
// its own stack model, predicts one report word per accepted command and
// compares every report word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bsmr_checker
  import bsmr_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_push_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic               out_is_empty,
  input  logic               out_is_full,
  input  logic [5:0]         out_depth,
  input  logic signed [31:0] out_min_value,
  input  logic [5:0]         out_min_rank,
  output int                 fail_count,
  output int                 reports_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_empty;
    logic               is_full;
    logic [5:0]         depth;
    logic signed [31:0] min_value;
    logic [5:0]         min_rank;
  } stack_report_t;

  // running minimum of levels 0..i and the slot of its topmost occurrence
  logic signed [31:0] level_min[CAPACITY];
  int                 level_min_slot[CAPACITY];
  int                 stack_fill = 0;
  stack_report_t      pending_reports[$];

  function automatic stack_report_t advance_stack(input logic [1:0] cmd,
                                                  input logic signed [31:0] value);
    stack_report_t r;
    r = '0;
    r.status = ST_DONE;
    case (cmd)
      CMD_PUSH: begin
        if (stack_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal value wins: it sits above the older one
          if (stack_fill == 0 || value <= level_min[stack_fill-1]) begin
            level_min[stack_fill] = value;
            level_min_slot[stack_fill] = stack_fill;
          end else begin
            level_min[stack_fill] = level_min[stack_fill-1];
            level_min_slot[stack_fill] = level_min_slot[stack_fill-1];
          end
          stack_fill++;
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else stack_fill--;
      end
      CMD_CLEAR: stack_fill = 0;
      default: ;  // unused code only reports the current state
    endcase
    r.is_empty = (stack_fill == 0);
    r.is_full  = (stack_fill == CAPACITY);
    r.depth    = 6'(stack_fill);
    if (stack_fill > 0) begin
      r.min_value = level_min[stack_fill-1];
      r.min_rank  = 6'(stack_fill - level_min_slot[stack_fill-1]);
    end
    return r;
  endfunction

  function automatic int field_differs(input string name, input longint want,
                                       input longint got);
    if (want == got) return 0;
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  function automatic int count_mismatches(input stack_report_t want,
                                          input stack_report_t got);
    int n;
    n = 0;
    n += field_differs("status", want.status, got.status);
    n += field_differs("is_empty", want.is_empty, got.is_empty);
    n += field_differs("is_full", want.is_full, got.is_full);
    n += field_differs("depth", want.depth, got.depth);
    n += field_differs("min_value", want.min_value, got.min_value);
    n += field_differs("min_rank", want.min_rank, got.min_rank);
    return n;
  endfunction

  always @(posedge clk) begin : monitor
    int            errs;
    stack_report_t got;
    stack_report_t want;
    errs = 0;
    if (!rst_n) begin
      stack_fill = 0;
      pending_reports.delete();
    end else begin
      // report word first: it can never belong to a command taken at this edge
      if (out_valid && !out_stall) begin
        got.status    = out_status;
        got.is_empty  = out_is_empty;
        got.is_full   = out_is_full;
        got.depth     = out_depth;
        got.min_value = out_min_value;
        got.min_rank  = out_min_rank;
        if (pending_reports.size() == 0) begin
          $error("report word with no command waiting for it");
          errs++;
        end else begin
          want = pending_reports.pop_front();
          errs += count_mismatches(want, got);
        end
      end
      if (in_valid && !in_stall)
        pending_reports.push_back(advance_stack(in_cmd, in_push_value));
    end
    fail_count   <= fail_count + errs;
    reports_owed <= pending_reports.size();
  end

endmodule

[test/bounded_stack_with_min_rank_tb.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_min_rank_tb
// Drives push, pop, clear and the unused command into the min-tracking stack
// with random idling on both channels: a directed opening, then fill, drain
// and mixed episodes with tie-prone values. The checker predicts and compares.
// ----------------------------------------------------------------------------
module bounded_stack_with_min_rank_tb
  import bsmr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CAPACITY   = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         WORD_TOTAL = 540;
  localparam int         CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = CMD_PUSH;
  logic signed [31:0] in_push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic               out_is_empty;
  logic               out_is_full;
  logic [5:0]         out_depth;
  logic signed [31:0] out_min_value;
  logic [5:0]         out_min_rank;
  int                 fail_count;
  int                 reports_owed;

  int          send_idle_pct = 12;
  int          recv_idle_pct = 62;
  int          words_sent = 0;
  int          stim_fill = 0;
  int          cycle_count = 0;
  logic [31:0] last_value = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_stack_with_min_rank #(.CAPACITY(CAPACITY)) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_push_value,
    .out_valid, .out_stall, .out_status, .out_is_empty, .out_is_full,
    .out_depth, .out_min_value, .out_min_rank
  );

  bsmr_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_push_value,
    .out_valid, .out_stall, .out_status, .out_is_empty, .out_is_full,
    .out_depth, .out_min_value, .out_min_rank, .fail_count, .reports_owed
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // small values and repeats make ties common
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(8) - 4;
      7:          return 32'h8000_0000;
      8:          return 32'h7fff_ffff;
      default:    return last_value;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] value);
    // each cycle the sender may sit idle
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (cmd)
      CMD_PUSH: begin
        if (stim_fill < CAPACITY) stim_fill++;
        last_value = value;
      end
      CMD_POP:   if (stim_fill > 0) stim_fill--;
      CMD_CLEAR: stim_fill = 0;
      default: ;
    endcase
    words_sent++;
  endtask

  task automatic fill_up();
    while (stim_fill < CAPACITY) begin
      if ($urandom_range(7) == 0) send_word(CMD_POP, $urandom);
      else send_word(CMD_PUSH, pick_value());
    end
    repeat ($urandom_range(1, 2)) send_word(CMD_PUSH, pick_value());
  endtask

  task automatic drain();
    while (stim_fill > 0) send_word(CMD_POP, $urandom);
    send_word(CMD_POP, $urandom);
  endtask

  task automatic mixed_burst();
    int          pick;
    logic [1:0]  cmd;
    repeat ($urandom_range(4, 12)) begin
      pick = $urandom_range(99);
      if (pick < 52) cmd = CMD_PUSH;
      else if (pick < 88) cmd = CMD_POP;
      else if (pick < 94) cmd = CMD_CLEAR;
      else cmd = CMD_UNUSED;
      send_word(cmd, (cmd == CMD_PUSH) ? pick_value() : $urandom);
    end
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_owed != 0);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: refusals, extremes, ties, unused code
    send_word(CMD_POP, 32'h0);
    send_word(CMD_UNUSED, 32'hffff_ffff);
    send_word(CMD_CLEAR, 32'h0);
    send_word(CMD_PUSH, 32'h7fff_ffff);
    send_word(CMD_PUSH, 32'd5);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_PUSH, 32'd100);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_UNUSED, 32'h0);
    send_word(CMD_POP, 32'h0);
    send_word(CMD_POP, 32'h0);
    send_word(CMD_POP, 32'h0);
    send_word(CMD_PUSH, 32'hffff_ffff);
    send_word(CMD_PUSH, 32'hffff_ffff);
    send_word(CMD_PUSH, 32'h0);
    send_word(CMD_CLEAR, 32'h0);
    send_word(CMD_POP, 32'h0);
    send_word(CMD_PUSH, 32'h5555_5555);
    send_word(CMD_PUSH, 32'haaaa_aaaa);
    send_word(CMD_POP, 32'h0);
    send_word(CMD_POP, 32'h0);
    send_word(CMD_POP, 32'h0);

    // full stack reached early, then random episodes
    fill_up();
    drain();
    while (words_sent < WORD_TOTAL) begin
      if (words_sent >= WORD_TOTAL * 2 / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (words_sent >= WORD_TOTAL / 3) begin
        if (!paused) begin
          wait_for_reports();
          paused = 1'b1;
        end
        send_idle_pct = 62;
        recv_idle_pct = 12;
      end
      case ($urandom_range(9))
        0, 1:    fill_up();
        2, 3:    drain();
        4:       send_word(CMD_CLEAR, $urandom);
        default: mixed_burst();
      endcase
    end

    wait_for_reports();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/bsmr_pkg.sv
design/bsmr_level_mem.sv
design/bounded_stack_with_min_rank.sv
test/bsmr_checker.sv
test/bounded_stack_with_min_rank_tb.sv
